[rtl/vwd_pkg.sv]
`default_nettype none

package vwd_pkg;

  localparam int COORD_W = 32;
  localparam int INDEX_W = 11;
  // hash bits folded into the slot remainder per cycle
  localparam int MOD_BITS = 4;

  localparam logic [COORD_W-1:0] GOLDEN = 32'h9e3779b9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MOD,
    ST_PROBE,
    ST_OWNER,
    ST_CHECK
  } vwd_state_t;

  function automatic logic [COORD_W-1:0] mix_step(input logic [COORD_W-1:0] h,
                                                  input logic [COORD_W-1:0] v);
    return h ^ (v + GOLDEN + {h[COORD_W-7:0], 6'b0} + {2'b0, h[COORD_W-1:2]});
  endfunction

endpackage

`default_nettype wire

[rtl/vertex_weld_dedup_unit.sv]
// sequence: an accepted vertex passes ST_MIX, then ST_MOD when HASH_SLOTS is not a power of
//   two (serial slot modulo), then ST_PROBE, ST_OWNER and ST_CHECK for each probe
// throughput: a new vertex is held off by in_stall until the last leaves ST_CHECK, which
//   out_stall can hold; each probe is a slot memory read then a dependent owner memory read
// reset: control state and the distinct count clear; the memories are not swept, a slot
//   counts as filled only when its index is below the count and the owner memory points back
`default_nettype none

module vertex_weld_dedup_unit #(
  parameter int HASH_SLOTS   = 4096,
  parameter int MAX_VERTICES = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [vwd_pkg::COORD_W-1:0]   in_x_bits,
  input  wire logic [vwd_pkg::COORD_W-1:0]   in_y_bits,
  input  wire logic [vwd_pkg::COORD_W-1:0]   in_z_bits,
  input  wire logic                          in_starts_mesh,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vwd_pkg::INDEX_W-1:0]        out_vertex_index,
  output logic                               out_is_new,
  output logic                               out_overflow
);

  localparam int CRD_W     = vwd_pkg::COORD_W;
  localparam int OUT_W     = vwd_pkg::INDEX_W;
  localparam int MB        = vwd_pkg::MOD_BITS;
  localparam int SW        = $clog2(HASH_SLOTS);
  localparam int IW        = $clog2(MAX_VERTICES);
  localparam int CW        = IW + 1;
  localparam int KEY_W     = 3 * CRD_W;
  localparam int ENT_W     = KEY_W + IW;
  localparam int IDX_DEPTH = 1 << IW;
  localparam int MOD_STEPS = CRD_W / MB;
  localparam int MCW       = $clog2(MOD_STEPS);
  localparam bit SLOTS_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
  localparam logic [SW:0]    SLOTS_EXT = (SW + 1)'(HASH_SLOTS);
  localparam logic [SW-1:0]  SLOT_LAST = SW'(HASH_SLOTS - 1);
  localparam logic [CW-1:0]  MAX_CNT   = CW'(MAX_VERTICES);
  localparam logic [MCW-1:0] MOD_LAST  = MCW'(MOD_STEPS - 1);

  // one restoring step per hash bit, MB bits per cycle
  function automatic logic [SW-1:0] mod_fold(input logic [SW-1:0] rem,
                                             input logic [MB-1:0] bits);
    logic [SW:0]   t;
    logic [SW-1:0] r;
    r = rem;
    for (int i = MB - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= SLOTS_EXT) t = t - SLOTS_EXT;
      r = t[SW-1:0];
    end
    return r;
  endfunction

  vwd_pkg::vwd_state_t state_r, state_nxt;

  logic [CRD_W-1:0] x_r, y_r, z_r;
  logic [CRD_W-1:0] h_r;
  logic [CRD_W-1:0] h_mix;
  logic [SW-1:0]    slot_r;
  logic [SW-1:0]    probe_r;
  logic [MCW-1:0]   mod_cnt_r;
  logic [CW-1:0]    count_r;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_index_r, out_index_nxt;
  logic             out_new_r;
  logic             out_ovf_r;

  // slot memory holds key and dense index, owner memory maps index back to slot
  logic [ENT_W-1:0] slot_mem [HASH_SLOTS];
  logic [SW-1:0]    owner_mem [IDX_DEPTH];
  logic [ENT_W-1:0] slot_rd_r;
  logic [SW-1:0]    owner_rd_r;

  logic [KEY_W-1:0] rd_key;
  logic [IW-1:0]    rd_idx;
  logic             in_fire;
  logic             out_free;
  logic             live;
  logic             key_eq;
  logic             res_hit, res_ins, res_ovf;
  logic             res_done, res_fire, ins_fire;
  logic             advance;

  assign rd_key = slot_rd_r[ENT_W-1:IW];
  assign rd_idx = slot_rd_r[IW-1:0];
  assign h_mix  = vwd_pkg::mix_step(h_r, z_r);

  assign in_stall = (state_r != vwd_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign live   = ({1'b0, rd_idx} < count_r) && (owner_rd_r == slot_r);
  assign key_eq = (rd_key == {x_r, y_r, z_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vwd_pkg::ST_IDLE:  if (in_fire) state_nxt = vwd_pkg::ST_MIX;
      vwd_pkg::ST_MIX:   state_nxt = SLOTS_POW2 ? vwd_pkg::ST_PROBE : vwd_pkg::ST_MOD;
      vwd_pkg::ST_MOD:   if (mod_cnt_r == MOD_LAST) state_nxt = vwd_pkg::ST_PROBE;
      vwd_pkg::ST_PROBE: state_nxt = vwd_pkg::ST_OWNER;
      vwd_pkg::ST_OWNER: state_nxt = vwd_pkg::ST_CHECK;
      vwd_pkg::ST_CHECK: begin
        if (res_done && out_free) state_nxt = vwd_pkg::ST_IDLE;
        else if (advance) state_nxt = vwd_pkg::ST_PROBE;
      end
      default: state_nxt = vwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_hit       = 1'b0;
    res_ins       = 1'b0;
    res_ovf       = 1'b0;
    advance       = 1'b0;
    out_index_nxt = '0;
    unique case (state_r)
      vwd_pkg::ST_CHECK: begin
        // an unknown or stale entry takes the empty-slot branch
        if (live) begin
          if (key_eq) begin
            res_hit       = 1'b1;
            out_index_nxt = OUT_W'(rd_idx);
          end else if (probe_r == SLOT_LAST) begin
            res_ovf = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end else begin
          if (count_r < MAX_CNT) begin
            res_ins       = 1'b1;
            out_index_nxt = OUT_W'(count_r);
          end else begin
            res_ovf = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_done = res_hit || res_ins || res_ovf;
  assign res_fire = res_done && out_free;
  assign ins_fire = res_fire && res_ins;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vwd_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_starts_mesh) count_r <= '0;
      else if (ins_fire) count_r <= count_r + 1'b1;
      if (res_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r <= in_x_bits;
      y_r <= in_y_bits;
      z_r <= in_z_bits;
      h_r <= vwd_pkg::mix_step(in_x_bits, in_y_bits);
    end
    unique case (state_r)
      vwd_pkg::ST_MIX: begin
        probe_r   <= '0;
        mod_cnt_r <= '0;
        if (SLOTS_POW2) begin
          slot_r <= h_mix[SW-1:0];
        end else begin
          slot_r <= '0;
          h_r    <= h_mix;
        end
      end
      vwd_pkg::ST_MOD: begin
        slot_r    <= mod_fold(slot_r, h_r[CRD_W-1 -: MB]);
        h_r       <= {h_r[CRD_W-MB-1:0], {MB{1'b0}}};
        mod_cnt_r <= mod_cnt_r + 1'b1;
      end
      vwd_pkg::ST_CHECK: begin
        if (advance) begin
          slot_r  <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
          probe_r <= probe_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (res_fire) begin
      out_index_r <= out_index_nxt;
      out_new_r   <= res_ins;
      out_ovf_r   <= res_ovf;
    end
  end

  always_ff @(posedge clk) begin
    slot_rd_r  <= slot_mem[slot_r];
    owner_rd_r <= owner_mem[rd_idx];
    if (ins_fire) begin
      slot_mem[slot_r]       <= {x_r, y_r, z_r, IW'(count_r)};
      owner_mem[IW'(count_r)] <= slot_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_index_r;
  assign out_is_new       = out_new_r;
  assign out_overflow     = out_ovf_r;

  a_new_not_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_ovf_r))
    else $error("result flagged both new and overflow");

  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> (count_r == '0 || $past(ins_fire)))
    else $error("distinct count changed without insert or mesh start");

  a_probe_timing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vwd_pkg::ST_PROBE |=> state_r == vwd_pkg::ST_OWNER ##1
      state_r == vwd_pkg::ST_CHECK)
    else $error("probe read sequence broken");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> $onehot({res_hit, res_ins, res_ovf}))
    else $error("more than one result kind decided");

endmodule

`default_nettype wire
